@@ hdl/dea_pkg.sv @@
// Shared types and constants for the decimal exponent adder/subtractor.
// No dependencies; every other file in hdl/ imports this package.
package dea_pkg;

  localparam int MantW = 32;
  localparam int ExpW  = 8;

  // normalize while the value lies in [-NormLimit, NormLimit-1]
  localparam int NormLimit = 214748364;
  localparam int FlushExp  = -5;
  localparam int ExpMax    = 127;

  // ceil(2^35 / 10): exact quotient by ten for any 32-bit magnitude
  localparam logic [MantW-1:0] Div10Recip = 32'hCCCC_CCCD;
  localparam int Div10Shift = 35;

  typedef enum logic [0:0] {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ALIGN  = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_PRE_A  = 8'b0000_1000,
    ST_PRE_B  = 8'b0001_0000,
    ST_SUM    = 8'b0010_0000,
    ST_NORM   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

endpackage

@@ hdl/dea_in_if.sv @@
// Operand channel: valid/ready handshake carrying one add/subtract request.
// Depends on dea_pkg for field widths.
interface dea_in_if;
  import dea_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [MantW-1:0] mant_a;
  logic signed [ExpW-1:0]  exp_a;
  logic signed [MantW-1:0] mant_b;
  logic signed [ExpW-1:0]  exp_b;

  modport source (output valid, cmd, mant_a, exp_a, mant_b, exp_b, input ready);
  modport sink   (input valid, cmd, mant_a, exp_a, mant_b, exp_b, output ready);
endinterface

@@ hdl/dea_out_if.sv @@
// Result channel: valid/ready handshake carrying one normalized result.
// Depends on dea_pkg for field widths.
interface dea_out_if;
  import dea_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MantW-1:0] mant_res;
  logic signed [ExpW-1:0]  exp_res;

  modport source (output valid, mant_res, exp_res, input ready);
  modport sink   (input valid, mant_res, exp_res, output ready);
endinterface

@@ hdl/decimal_exponent_add_sub_top.sv @@
// Decimal exponent add/subtract: one item at a time through a sequencer around a
// single shared divide-by-ten / multiply-by-ten unit (one use per cycle).
// Alignment takes up to 10 divides, normalization up to 9 multiplies.
// The result register lets the next beat in while a result waits.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops valid.
module decimal_exponent_add_sub_top (
  input  logic      clk,
  input  logic      rst,
  dea_in_if.sink    operands,
  dea_out_if.source result
);
  import dea_pkg::*;

  state_t state;

  logic                    sub;
  logic signed [MantW-1:0] a;
  logic signed [MantW-1:0] b;
  logic signed [ExpW-1:0]  ea;
  logic signed [ExpW-1:0]  eb;
  logic signed [ExpW:0]    e;
  logic signed [MantW-1:0] s;

  logic                    res_valid;
  logic signed [MantW-1:0] res_mant;
  logic signed [ExpW-1:0]  res_exp;

  // shared unit
  logic                    unit_mul;
  logic signed [MantW-1:0] unit_x;
  logic        [MantW-1:0] unit_mag;
  logic        [2*MantW-1:0] unit_prod;
  logic        [MantW-1:0] unit_quo;
  logic signed [MantW-1:0] unit_y;

  logic signed [MantW:0]   sum_ab;
  logic                    in_norm_range;

  always_comb begin
    unit_mul = (state == ST_NORM);
    case (state)
      ST_ALIGN: unit_x = (ea > eb) ? b : a;
      ST_PRE_A: unit_x = a;
      ST_PRE_B: unit_x = b;
      ST_NORM:  unit_x = s;
      default:  unit_x = '0;
    endcase
    unit_mag  = unit_x[MantW-1] ? (MantW'(0) - unit_x) : unit_x;
    unit_prod = (2*MantW)'(unit_mag) * (2*MantW)'(Div10Recip);
    unit_quo  = MantW'(unit_prod[2*MantW-1:Div10Shift]);
    if (unit_mul) begin
      unit_y = (unit_x <<< 3) + (unit_x <<< 1);
    end else if (unit_x[MantW-1]) begin
      unit_y = MantW'(0) - unit_quo;
    end else begin
      unit_y = unit_quo;
    end
  end

  always_comb begin
    if (sub == CMD_SUB) begin
      sum_ab = $signed({a[MantW-1], a}) - $signed({b[MantW-1], b});
    end else begin
      sum_ab = $signed({a[MantW-1], a}) + $signed({b[MantW-1], b});
    end
    in_norm_range = (s < NormLimit) && (s >= -NormLimit);
  end

  assign operands.ready  = (state == ST_IDLE);
  assign result.valid    = res_valid;
  assign result.mant_res = res_mant;
  assign result.exp_res  = res_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // finish reloads the register itself, so leave valid to it there
      if (result.ready && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (operands.valid) begin
            sub   <= operands.cmd;
            a     <= operands.mant_a;
            b     <= operands.mant_b;
            ea    <= operands.exp_a;
            eb    <= operands.exp_b;
            state <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          // shrink the smaller-exponent mantissa until exponents meet or it hits zero
          if (ea > eb && b != '0) begin
            b  <= unit_y;
            eb <= eb + 8'sd1;
          end else if (eb > ea && a != '0) begin
            a  <= unit_y;
            ea <= ea + 8'sd1;
          end else begin
            e     <= (ea > eb) ? (ExpW+1)'(ea) : (ExpW+1)'(eb);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sum_ab == '0) begin
            s     <= '0;
            e     <= '0;
            state <= ST_FINISH;
          end else begin
            state <= ST_PRE_A;
          end
        end
        ST_PRE_A: begin
          a     <= unit_y;
          state <= ST_PRE_B;
        end
        ST_PRE_B: begin
          b     <= unit_y;
          e     <= e + 9'sd1;
          state <= ST_SUM;
        end
        ST_SUM: begin
          s <= MantW'(sum_ab);
          if (sum_ab == '0) begin
            e     <= '0;
            state <= ST_FINISH;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (in_norm_range) begin
            s <= unit_y;
            e <= e - 9'sd1;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the result register is free
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            if (e <= FlushExp) begin
              res_mant <= '0;
              res_exp  <= '0;
            end else if (e > ExpMax) begin
              res_mant <= s;
              res_exp  <= ExpW'(ExpMax);
            end else begin
              res_mant <= s;
              res_exp  <= ExpW'(e);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.mant_res == '0 |-> result.exp_res == '0)
    else $error("zero result with nonzero exponent");

  a_normalized: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.mant_res != '0 |->
      result.mant_res >= NormLimit || result.mant_res < -NormLimit)
    else $error("result mantissa not normalized");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.mant_res != '0 |-> result.exp_res > FlushExp)
    else $error("nonzero result below flush exponent");

  a_start_align: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> state == ST_ALIGN)
    else $error("accepted beat did not start alignment");
`endif

endmodule
